@@ hdl/vts_pkg.sv @@
package vts_pkg;

  localparam int STORE_DEPTH = 32768;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int FRAC_SHIFT  = SAMPLE_BITS - 8;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Register indexes
  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [2:0] REG_INV_STEP_X = 3'd3;
  localparam logic [2:0] REG_INV_STEP_Y = 3'd4;
  localparam logic [2:0] REG_INV_STEP_Z = 3'd5;
  localparam logic [2:0] REG_DIM_X      = 3'd6;
  localparam logic [2:0] REG_DIM_Y      = 3'd7;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [31:0]        inv_step_x;
    logic [31:0]        inv_step_y;
    logic [31:0]        inv_step_z;
    logic [10:0]        dim_x;
    logic [10:0]        dim_y;
  } cfg_t;

  // Memory port command from the sequencer
  typedef struct packed {
    logic                     wr;
    logic                     rd;
    logic [ADDR_BITS-1:0]     addr;
    logic [SAMPLE_BITS-1:0]   wdata;
  } mem_cmd_t;

endpackage

@@ hdl/volume_trilinear_sampler.sv @@
// Trilinear sampler over a 3-D volume held in a 32768-entry single-port
// sample memory. A load word writes one sample and returns no result; the
// next word can be taken on the following cycle. A query word maps the
// point to grid units on the shared mapping multiplier, checks range and
// reads the eight corners one per cycle from the one memory port, blending
// each pair along x as it arrives, then blends along y and z; a point below
// the origin or with corners past the store skips the reads and blends and
// is flagged out of range. One query is in work at a time; the result stays
// in an output register until taken, and the next word is accepted in the
// cycle after that.
module volume_trilinear_sampler (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [14:0]        sample_addr,
  input  logic [15:0]        sample_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [23:0]        value,
  output logic               out_of_range
);
  import vts_pkg::*;

  cfg_t                   cfg;
  mem_cmd_t               cmd;
  logic [SAMPLE_BITS-1:0] rdata;

  assign pready = 1'b1;

  vts_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  vts_store u_store (.clk, .cmd, .rdata);

  vts_core u_core (
    .clk, .rst, .cfg, .in_valid, .in_ready, .kind, .sample_addr,
    .sample_value, .point_x, .point_y, .point_z, .cmd, .rdata,
    .out_valid, .out_ready, .value, .out_of_range
  );

endmodule

@@ hdl/vts_regs.sv @@
module vts_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output vts_pkg::cfg_t      cfg
);
  import vts_pkg::*;

  logic [2:0] idx;
  assign idx = paddr[4:2];

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x   <= '0;
      cfg.origin_y   <= '0;
      cfg.origin_z   <= '0;
      cfg.inv_step_x <= 32'h10000;
      cfg.inv_step_y <= 32'h10000;
      cfg.inv_step_z <= 32'h10000;
      cfg.dim_x      <= 11'd32;
      cfg.dim_y      <= 11'd32;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_ORIGIN_X:   cfg.origin_x   <= pwdata;
        REG_ORIGIN_Y:   cfg.origin_y   <= pwdata;
        REG_ORIGIN_Z:   cfg.origin_z   <= pwdata;
        REG_INV_STEP_X: cfg.inv_step_x <= pwdata;
        REG_INV_STEP_Y: cfg.inv_step_y <= pwdata;
        REG_INV_STEP_Z: cfg.inv_step_z <= pwdata;
        REG_DIM_X:      cfg.dim_x      <= pwdata[10:0];
        REG_DIM_Y:      cfg.dim_y      <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ORIGIN_X:   prdata = cfg.origin_x;
      REG_ORIGIN_Y:   prdata = cfg.origin_y;
      REG_ORIGIN_Z:   prdata = cfg.origin_z;
      REG_INV_STEP_X: prdata = cfg.inv_step_x;
      REG_INV_STEP_Y: prdata = cfg.inv_step_y;
      REG_INV_STEP_Z: prdata = cfg.inv_step_z;
      REG_DIM_X:      prdata = {21'd0, cfg.dim_x};
      REG_DIM_Y:      prdata = {21'd0, cfg.dim_y};
      default:        prdata = '0;
    endcase
  end

endmodule

@@ hdl/vts_store.sv @@
module vts_store (
  input  logic                          clk,
  input  vts_pkg::mem_cmd_t             cmd,
  output logic [vts_pkg::SAMPLE_BITS-1:0] rdata
);
  import vts_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[cmd.addr];
    end
  end

endmodule

@@ hdl/vts_core.sv @@
module vts_core (
  input  logic                    clk,
  input  logic                    rst,
  input  vts_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic [14:0]             sample_addr,
  input  logic [15:0]             sample_value,
  input  logic signed [31:0]      point_x,
  input  logic signed [31:0]      point_y,
  input  logic signed [31:0]      point_z,
  output vts_pkg::mem_cmd_t       cmd,
  input  logic [vts_pkg::SAMPLE_BITS-1:0] rdata,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [23:0]             value,
  output logic                    out_of_range
);
  import vts_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MAP   = 8'b00000010,
    S_ADDR1 = 8'b00000100,
    S_ADDR2 = 8'b00001000,
    S_CHECK = 8'b00010000,
    S_READ  = 8'b00100000,
    S_BLEND = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state;

  // Query operands
  logic signed [31:0] px, py, pz;
  logic [1:0]         axis;
  logic [32:0]        dx, dy, dz;
  logic               neg;
  logic [47:0]        gx, gy, gz;     // grid coordinate, Q.16
  logic [63:0]        prod;
  logic [22:0]        sz;             // z stride
  logic [63:0]        base;
  logic [3:0]         rd_cnt;
  logic [63:0]        rd_addr;
  logic [SAMPLE_BITS-1:0] s0;
  logic [SAMPLE_BITS+16:0] cx [4];
  logic [SAMPLE_BITS+16:0] cy [2];
  logic [2:0]         blend_cnt;

  logic [15:0] fx, fy, fz;
  assign fx = gx[15:0];
  assign fy = gy[15:0];
  assign fz = gz[15:0];

  // One shared 33x32 multiplier, one axis per cycle
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  always_comb begin
    case (axis)
      2'd0:    begin mul_a = dx; mul_b = cfg.inv_step_x; end
      2'd1:    begin mul_a = dy; mul_b = cfg.inv_step_y; end
      default: begin mul_a = dz; mul_b = cfg.inv_step_z; end
    endcase
  end
  assign prod = {31'd0, mul_a} * {32'd0, mul_b};

  // Corner address for read rd_cnt: bit0 +1, bit1 +dim_x, bit2 +sz
  always_comb begin
    rd_addr = base + {63'd0, rd_cnt[0]}
            + (rd_cnt[1] ? {53'd0, cfg.dim_x} : 64'd0)
            + (rd_cnt[2] ? {41'd0, sz} : 64'd0);
  end

  // Blend of one pair: a*(1-f) + b*f
  logic [SAMPLE_BITS+16:0] bl_a, bl_b, bl_res;
  logic [15:0]             bl_f;
  logic [SAMPLE_BITS+34:0] bl_sum;
  assign bl_sum = {18'd0, bl_a} * {{SAMPLE_BITS+18{1'b0}}, (ONE_Q16 - {1'b0, bl_f})}
                + {18'd0, bl_b} * {{SAMPLE_BITS+19{1'b0}}, bl_f};
  always_comb begin
    bl_a = '0; bl_b = '0; bl_f = fx; bl_res = '0;
    case (blend_cnt)
      3'd0: begin bl_a = cx[0]; bl_b = cx[1]; bl_f = fy;
                  bl_res = bl_sum[SAMPLE_BITS+32:16]; end
      3'd1: begin bl_a = cx[2]; bl_b = cx[3]; bl_f = fy;
                  bl_res = bl_sum[SAMPLE_BITS+32:16]; end
      default: begin bl_a = cy[0]; bl_b = cy[1]; bl_f = fz;
                  bl_res = bl_sum[SAMPLE_BITS+32:16]; end
    endcase
  end

  logic [SAMPLE_BITS+16:0] xs;
  assign xs = {1'b0, s0, 16'd0}
            - {{SAMPLE_BITS{1'b0}}, 1'b0, s0} * {{SAMPLE_BITS{1'b0}}, 1'b0, fx}
            + {{SAMPLE_BITS{1'b0}}, 1'b0, rdata} * {{SAMPLE_BITS{1'b0}}, 1'b0, fx};

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Memory command
  always_comb begin
    cmd.wr    = 1'b0;
    cmd.rd    = 1'b0;
    cmd.addr  = rd_addr[ADDR_BITS-1:0];
    cmd.wdata = sample_value[SAMPLE_BITS-1:0];
    if (state == S_IDLE && in_valid && in_ready && kind == KIND_LOAD) begin
      cmd.wr   = ({17'd0, sample_addr} < 32'(STORE_DEPTH));
      cmd.addr = sample_addr[ADDR_BITS-1:0];
    end else if (state == S_READ && rd_cnt < 4'd8) begin
      cmd.rd = 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      neg       <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready && kind == KIND_QUERY) begin
            px <= point_x; py <= point_y; pz <= point_z;
            state <= S_MAP;
            axis <= 2'd0;
          end
        end
        S_MAP: begin
          // differences first, then three multiplies
          if (axis == 2'd0 && !neg) begin
            neg <= 1'b1; // marks differences ready
            dx <= 33'({px[31], px}) - 33'({cfg.origin_x[31], cfg.origin_x});
            dy <= 33'({py[31], py}) - 33'({cfg.origin_y[31], cfg.origin_y});
            dz <= 33'({pz[31], pz}) - 33'({cfg.origin_z[31], cfg.origin_z});
          end else begin
            case (axis)
              2'd0:    gx <= prod[63:16];
              2'd1:    gy <= prod[63:16];
              default: gz <= prod[63:16];
            endcase
            if (axis == 2'd2) begin
              neg <= 1'b0;
              state <= S_ADDR1;
            end
            axis <= axis + 2'd1;
          end
        end
        S_ADDR1: begin
          sz   <= 23'({12'd0, cfg.dim_x} * {12'd0, cfg.dim_y});
          base <= {32'd0, gx[47:16]} + 64'({32'd0, gy[47:16]} * {53'd0, cfg.dim_x});
          state <= S_ADDR2;
        end
        S_ADDR2: begin
          base <= base + 64'({32'd0, gz[47:16]} * {41'd0, sz});
          state <= S_CHECK;
        end
        S_CHECK: begin
          rd_cnt <= 4'd0;
          if (dx[32] || dy[32] || dz[32]) begin
            value <= '0; out_of_range <= 1'b1; state <= S_DONE;
          end else if (base + 64'd1 + {53'd0, cfg.dim_x} + {41'd0, sz}
                       >= 64'(STORE_DEPTH)) begin
            value <= '0; out_of_range <= 1'b1; state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          // data for read n-1 arrives while read n issues
          if (rd_cnt != 4'd0) begin
            if (rd_cnt[0]) s0 <= rdata;
            else cx[rd_cnt[2:1] - 2'd1] <= xs;
          end
          if (rd_cnt == 4'd8) begin
            state <= S_BLEND;
            blend_cnt <= 3'd0;
          end
          rd_cnt <= rd_cnt + 4'd1;
        end
        S_BLEND: begin
          if (blend_cnt == 3'd2) begin
            value <= 24'(bl_res >> FRAC_SHIFT);
            out_of_range <= 1'b0;
            state <= S_DONE;
          end else begin
            cy[blend_cnt[0]] <= bl_res;
          end
          blend_cnt <= blend_cnt + 3'd1;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/vts_checker.sv @@
module vts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] value,
  input logic        out_of_range
);
  // Flagged result carries zero
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> value == 24'd0)
    else $error("out_of_range with nonzero value");

  // Held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("result dropped");

  // Load produces no result next cycle
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !kind |=> !out_valid)
    else $error("load made a result");

  // No accept while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("accept while result pending");
endmodule

bind volume_trilinear_sampler vts_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .kind, .out_valid, .out_ready,
  .value, .out_of_range
);
